[hdl/stpc_pkg.sv]
// Shared types, constants and the multiply sequence for the sigma threshold
// port classifier. Used by every module of the block; no dependencies.
package stpc_pkg;

    localparam int PORTS       = 65536;
    localparam int SAMPLE_BITS = 24;
    localparam int IDX_W       = $clog2(PORTS);
    localparam int CNT_W       = $clog2(PORTS + 1);

    localparam logic [31:0] SAMPLE_MAX = 32'((64'd1 << SAMPLE_BITS) - 64'd1);

    localparam int FACT_W = 24;
    localparam int SUM_W  = 40;
    localparam int SQ_W   = 64;
    localparam int D_W    = 41;
    localparam int V_W    = 81;
    localparam int G_W    = 48;
    localparam int PROD_W = 64;
    localparam int ACC_W  = 128;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 3;
    localparam int LOADED_W  = 17;
    localparam int STORED_W  = 24;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_QUERY = 5'd0;
    localparam logic [STEP_W-1:0] STEP_LOAD  = 5'd18;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_LOADED     = 3'd0,
        ST_DROPPED    = 3'd1,
        ST_ANSWERED   = 3'd2,
        ST_NOT_LOADED = 3'd3,
        ST_CLEARED    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    // 32-bit operand slices fed to the shared multiplier
    typedef enum logic [3:0] {
        L_N, L_X, L_W, L_F,
        L_D0, L_D1, L_S0, L_S1,
        L_Q0, L_Q1, L_V0, L_V1, L_V2,
        L_G0, L_G1
    } t_limb;

    typedef enum logic [2:0] {
        DST_NONE, DST_NX, DST_G, DST_V, DST_LHS, DST_RHS, DST_SQ
    } t_dest;

    typedef struct packed {
        t_limb       a;
        t_limb       b;
        logic [1:0]  shift;
        logic        sub;
        logic        first;
        t_dest       dest;
        logic        last;
    } t_uop;

    typedef struct packed {
        logic    cap_load;
        logic    cap_query;
        logic    clear;
        logic    issue;
        t_uop    uop;
        logic    out_load;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic idx_ok;
    } t_dp_stat;

    function automatic t_uop uop_mk(input t_limb a, input t_limb b, input logic [1:0] shift,
                                    input logic sub, input logic first, input t_dest dest,
                                    input logic last);
        t_uop u;
        u.a     = a;
        u.b     = b;
        u.shift = shift;
        u.sub   = sub;
        u.first = first;
        u.dest  = dest;
        u.last  = last;
        return u;
    endfunction

    // Query: nx, F^2, V = nQ - S^2, d^2, F^2*V. Load: sample squared.
    function automatic t_uop uop_rom(input logic [STEP_W-1:0] step);
        t_uop u;
        case (step)
            5'd0:    u = uop_mk(L_N,  L_X,  2'd0, 1'b0, 1'b1, DST_NX,   1'b0);
            5'd1:    u = uop_mk(L_F,  L_F,  2'd0, 1'b0, 1'b1, DST_G,    1'b0);
            5'd2:    u = uop_mk(L_N,  L_Q0, 2'd0, 1'b0, 1'b1, DST_NONE, 1'b0);
            5'd3:    u = uop_mk(L_N,  L_Q1, 2'd1, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd4:    u = uop_mk(L_S0, L_S0, 2'd0, 1'b1, 1'b0, DST_NONE, 1'b0);
            5'd5:    u = uop_mk(L_S0, L_S1, 2'd1, 1'b1, 1'b0, DST_NONE, 1'b0);
            5'd6:    u = uop_mk(L_S1, L_S0, 2'd1, 1'b1, 1'b0, DST_NONE, 1'b0);
            5'd7:    u = uop_mk(L_S1, L_S1, 2'd2, 1'b1, 1'b0, DST_V,    1'b0);
            5'd8:    u = uop_mk(L_D0, L_D0, 2'd0, 1'b0, 1'b1, DST_NONE, 1'b0);
            5'd9:    u = uop_mk(L_D0, L_D1, 2'd1, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd10:   u = uop_mk(L_D1, L_D0, 2'd1, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd11:   u = uop_mk(L_D1, L_D1, 2'd2, 1'b0, 1'b0, DST_LHS,  1'b0);
            5'd12:   u = uop_mk(L_G0, L_V0, 2'd0, 1'b0, 1'b1, DST_NONE, 1'b0);
            5'd13:   u = uop_mk(L_G0, L_V1, 2'd1, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd14:   u = uop_mk(L_G0, L_V2, 2'd2, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd15:   u = uop_mk(L_G1, L_V0, 2'd1, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd16:   u = uop_mk(L_G1, L_V1, 2'd2, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd17:   u = uop_mk(L_G1, L_V2, 2'd3, 1'b0, 1'b0, DST_RHS,  1'b1);
            5'd18:   u = uop_mk(L_W,  L_W,  2'd0, 1'b0, 1'b1, DST_SQ,   1'b1);
            default: u = uop_mk(L_N,  L_N,  2'd0, 1'b0, 1'b1, DST_NONE, 1'b1);
        endcase
        return u;
    endfunction

endpackage

[hdl/stpc_ctrl.sv]
// Controller for the sigma threshold port classifier: request decode,
// multiply sequencing and stream handshakes. Depends on stpc_pkg.
module stpc_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [stpc_pkg::S_TUSER_W-1:0]      i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  stpc_pkg::t_dp_stat                  i_stat,
    output stpc_pkg::t_dp_cmd                   o_cmd
);
    import stpc_pkg::*;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    t_status             r_status, n_status;
    logic                r_out_vld, n_out_vld;
    logic                accept;
    logic                out_free;
    t_uop                cur_uop;

    assign accept   = i_s_axis_tvalid && (r_state == S_IDLE);
    assign out_free = !r_out_vld || i_m_axis_tready;
    assign cur_uop  = uop_rom(r_step);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_req'(i_s_axis_tuser))
                        REQ_LOAD:  n_state = i_stat.full   ? S_DONE : S_RUN;
                        REQ_QUERY: n_state = i_stat.idx_ok ? S_RUN  : S_DONE;
                        REQ_CLEAR: n_state = S_DONE;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_RUN: begin
                if (cur_uop.last) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_status = r_status;
        if (accept) begin
            unique case (t_req'(i_s_axis_tuser))
                REQ_LOAD:  n_status = i_stat.full   ? ST_DROPPED  : ST_LOADED;
                REQ_QUERY: n_status = i_stat.idx_ok ? ST_ANSWERED : ST_NOT_LOADED;
                REQ_CLEAR: n_status = ST_CLEARED;
                default:   n_status = r_status;
            endcase
        end
    end

    always_comb begin
        n_step = r_step;
        if (accept) begin
            n_step = (t_req'(i_s_axis_tuser) == REQ_LOAD) ? STEP_LOAD : STEP_QUERY;
        end else if (r_state == S_RUN) begin
            n_step = r_step + 1'b1;
        end
    end

    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        o_cmd.cap_load  = accept && (t_req'(i_s_axis_tuser) == REQ_LOAD) && !i_stat.full;
        o_cmd.cap_query = accept && (t_req'(i_s_axis_tuser) == REQ_QUERY) && i_stat.idx_ok;
        o_cmd.clear     = accept && (t_req'(i_s_axis_tuser) == REQ_CLEAR);
        o_cmd.issue     = (r_state == S_RUN);
        o_cmd.uop       = cur_uop;
        o_cmd.out_load  = (r_state == S_DONE) && out_free;
        o_cmd.status    = r_status;
        n_out_vld       = o_cmd.out_load || (r_out_vld && !i_m_axis_tready);
    end

    assign o_m_axis_tvalid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_step    <= STEP_QUERY;
            r_status  <= ST_LOADED;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_step    <= n_step;
            r_status  <= n_status;
        end
    end

endmodule

[hdl/stpc_dpath.sv]
// Datapath for the sigma threshold port classifier: sample store, running
// sums, shared 32x32 multiply-accumulate and result register. Depends on stpc_pkg.
module stpc_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  stpc_pkg::t_dp_cmd                   i_cmd,
    output stpc_pkg::t_dp_stat                  o_stat,
    input  logic [stpc_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [stpc_pkg::FACT_W-1:0]         i_cfg_wdata,
    output logic [stpc_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,
    output logic [stpc_pkg::M_TUSER_W-1:0]      o_m_axis_tuser
);
    import stpc_pkg::*;

    logic [31:0]              sample_in;
    logic [15:0]              port_idx;
    logic [SAMPLE_BITS-1:0]   sample_sat;

    logic [FACT_W-1:0]        r_factor;
    logic [CNT_W-1:0]         r_loaded;
    logic [SUM_W-1:0]         r_sum;
    logic [SQ_W-1:0]          r_sq;
    logic [SAMPLE_BITS-1:0]   r_mem [PORTS];
    logic [SAMPLE_BITS-1:0]   r_rdata;
    logic [SAMPLE_BITS-1:0]   r_w;

    logic [PROD_W-1:0]        r_prod;
    t_uop                     r_p;
    logic                     r_p_vld;
    logic [ACC_W-1:0]         r_acc, n_acc;
    logic [D_W-1:0]           r_d;
    logic                     r_neg;
    logic [G_W-1:0]           r_g;
    logic [V_W-1:0]           r_v;
    logic [ACC_W-1:0]         r_lhs;
    logic [ACC_W-1:0]         r_rhs;
    logic [M_TDATA_W-1:0]     r_m_tdata;
    logic [M_TUSER_W-1:0]     r_m_tuser;

    logic [31:0]              op_a, op_b;
    logic [ACC_W-1:0]         shifted;
    logic [ACC_W-1:0]         acc_base;
    logic [D_W:0]             nx_diff;
    logic                     answered;
    logic                     port_open;
    logic [STORED_W-1:0]      stored;

    assign sample_in = i_s_axis_tdata[31:0];
    assign port_idx  = i_s_axis_tdata[47:32];
    assign sample_sat = (sample_in > SAMPLE_MAX) ? SAMPLE_MAX[SAMPLE_BITS-1:0]
                                                 : sample_in[SAMPLE_BITS-1:0];

    assign o_stat.full   = (r_loaded == CNT_W'(PORTS));
    assign o_stat.idx_ok = ({1'b0, port_idx} < LOADED_W'(r_loaded));

    function automatic logic [31:0] limb_val(input t_limb sel);
        logic [31:0] v;
        unique case (sel)
            L_N:  v = 32'(r_loaded);
            L_X:  v = 32'(r_rdata);
            L_W:  v = 32'(r_w);
            L_F:  v = 32'(r_factor);
            L_D0: v = r_d[31:0];
            L_D1: v = 32'(r_d[D_W-1:32]);
            L_S0: v = r_sum[31:0];
            L_S1: v = 32'(r_sum[SUM_W-1:32]);
            L_Q0: v = r_sq[31:0];
            L_Q1: v = r_sq[63:32];
            L_V0: v = r_v[31:0];
            L_V1: v = r_v[63:32];
            L_V2: v = 32'(r_v[V_W-1:64]);
            L_G0: v = r_g[31:0];
            L_G1: v = 32'(r_g[G_W-1:32]);
            default: v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        op_a = limb_val(i_cmd.uop.a);
        op_b = limb_val(i_cmd.uop.b);
    end

    // stage 2: shifted partial product into the 128-bit accumulator
    always_comb begin
        shifted  = ACC_W'(r_prod) << {r_p.shift, 5'b0};
        acc_base = r_p.first ? '0 : r_acc;
        n_acc    = r_p.sub ? (acc_base - shifted) : (acc_base + shifted);
        nx_diff  = {1'b0, n_acc[D_W-1:0]} - (D_W+1)'(r_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p    <= i_cmd.uop;
        r_prod <= {32'b0, op_a} * {32'b0, op_b};
        if (r_p_vld) begin
            r_acc <= n_acc;
            unique case (r_p.dest)
                DST_NX: begin
                    r_d   <= nx_diff[D_W-1:0];
                    r_neg <= nx_diff[D_W];
                end
                DST_G:   r_g   <= n_acc[G_W-1:0];
                DST_V:   r_v   <= n_acc[ACC_W-1] ? '0 : n_acc[V_W-1:0];
                DST_LHS: r_lhs <= {n_acc[ACC_W-33:0], 32'b0};
                DST_RHS: r_rhs <= n_acc;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= FACT_W'(6554);
            r_loaded <= '0;
            r_sum    <= '0;
            r_sq     <= '0;
        end else begin
            if (i_cfg_we) r_factor <= i_cfg_wdata;
            if (i_cmd.clear) begin
                r_loaded <= '0;
                r_sum    <= '0;
                r_sq     <= '0;
            end else if (i_cmd.cap_load) begin
                r_loaded <= r_loaded + 1'b1;
                r_sum    <= r_sum + SUM_W'(sample_sat);
            end else if (r_p_vld && (r_p.dest == DST_SQ)) begin
                r_sq <= r_sq + r_prod;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_load) begin
            r_mem[r_loaded[IDX_W-1:0]] <= sample_sat;
            r_w <= sample_sat;
        end
        if (i_cmd.cap_query) r_rdata <= r_mem[port_idx[IDX_W-1:0]];
    end

    assign answered  = (i_cmd.status == ST_ANSWERED);
    assign port_open = answered && !r_neg && (r_lhs >= r_rhs);
    assign stored    = answered ? STORED_W'(r_rdata) : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_m_tuser <= i_cmd.status;
            r_m_tdata <= {6'b0, LOADED_W'(r_loaded), stored, port_open};
        end
    end

    assign o_m_axis_tdata = r_m_tdata;
    assign o_m_axis_tuser = r_m_tuser;

endmodule

[hdl/sigma_threshold_port_classifier.sv]
// Top level of the sigma threshold port classifier: joins controller and
// datapath. Depends on stpc_pkg, stpc_ctrl and stpc_dpath.
//
// Input stream carries one request per word: tuser selects load, query or
// clear; tdata holds the sample (load) and the port index (query). A load
// appends a saturated sample to the store, unless full, and updates count, sum and
// sum of squares; a query reports the stored sample and whether it reaches
// mean + factor * stddev; a clear empties the sums. Request code 3 is dropped.
// Every other request gives exactly one output word.
// The config port writes the Q8.16 factor; write it only while idle.
// An answered query makes 18 passes through the single 32x32 multiplier,
// followed by the product and accumulator registers; an accepted load makes
// one multiply for the square; other requests use no multiply.
// One request is in flight at a time; tready returns in the same cycle that
// the result word turns valid.
// The output register lets a new request in while a result waits; a stalled
// receiver holds the block in its final cycle until the word is taken.
// Reset clears counts, sums and handshakes and restores the factor to 6554;
// the sample store is not cleared, entries are reachable only once loaded.
module sigma_threshold_port_classifier (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [31:0] sample_value, [47:32] port_index
    input  logic [stpc_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,
    // [1:0] req_type
    input  logic [stpc_pkg::S_TUSER_W-1:0]      i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [0] port_open, [24:1] stored_count, [41:25] loaded_total, [47:42] zero
    output logic [stpc_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,
    // [2:0] status
    output logic [stpc_pkg::M_TUSER_W-1:0]      o_m_axis_tuser,
    input  logic                                i_cfg_we,
    input  logic [stpc_pkg::FACT_W-1:0]         i_cfg_wdata
);
    import stpc_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    stpc_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_stat          (stat),
        .o_cmd           (cmd)
    );

    stpc_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

endmodule

[hdl/stpc_checker.sv]
// Port-level checks for the sigma threshold port classifier, bound to the
// top level. Depends on stpc_pkg and sigma_threshold_port_classifier.
module stpc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_axis_tvalid,
    input logic                                o_s_axis_tready,
    input logic [stpc_pkg::S_TUSER_W-1:0]      i_s_axis_tuser,
    input logic                                o_m_axis_tvalid,
    input logic                                i_m_axis_tready,
    input logic [stpc_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,
    input logic [stpc_pkg::M_TUSER_W-1:0]      o_m_axis_tuser
);
    import stpc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output word changed while stalled");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready &&
            (i_s_axis_tuser == REQ_LOAD || i_s_axis_tuser == REQ_QUERY ||
             i_s_axis_tuser == REQ_CLEAR) |=> !o_s_axis_tready)
        else $error("ready stayed high after a request was taken");

    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != ST_ANSWERED) |->
            (o_m_axis_tdata[24:0] == 25'd0))
        else $error("open flag or stored count set on a non-answer");

    a_clear_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == ST_CLEARED) |->
            (o_m_axis_tdata[41:25] == 17'd0))
        else $error("loaded total not zero after clear");

    a_full_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == ST_DROPPED) |->
            (o_m_axis_tdata[41:25] == LOADED_W'(PORTS)))
        else $error("load dropped while store not full");

endmodule

bind sigma_threshold_port_classifier stpc_checker u_stpc_checker (.*);

[tb/tb_sigma_threshold_port_classifier.sv]
// Self-checking testbench for sigma_threshold_port_classifier: drives request
// words with random idling, predicts every result word and compares it field by field.
// Depends on stpc_pkg and the block's RTL.
module tb_sigma_threshold_port_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    import stpc_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int         RUN_LIMIT   = 3_000_000;
    localparam int         DRAIN_WAIT  = 30;
    localparam int         HOLD_LEN    = 400;

    typedef struct {
        logic [1:0]  req;
        logic [31:0] sample;
        logic [15:0] idx;
    } t_word;

    typedef struct {
        t_status     status;
        logic        open;
        logic [23:0] stored;
        logic [16:0] loaded;
    } t_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] i_s_axis_tuser = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic [M_TUSER_W-1:0] o_m_axis_tuser;
    logic                 i_cfg_we = 1'b0;
    logic [FACT_W-1:0]    i_cfg_wdata = '0;

    sigma_threshold_port_classifier u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial forever #1 i_clk = ~i_clk;

    // predicted block state
    logic [23:0] sample_mem [0:PORTS-1];
    logic [16:0] n_loaded = '0;
    logic [39:0] sum_acc = '0;
    logic [63:0] sq_acc = '0;
    logic [23:0] factor = 24'd6554;

    t_word   pending_words[$];
    t_result expected_results[$];
    int      queued_total = 0;
    int      accepted_total = 0;
    int      errors = 0;
    int      cycle_cnt = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int stall_token = 0;
    int stall_seen = 0;
    int stall_left = 0;

    // stimulus generator view of the store fill level
    int          gen_loaded = 0;
    logic [31:0] cluster_base = 32'd1000;
    int          cluster_spread = 16;

    // d = n*x - S, V = n*Q - S^2; open when d >= 0 and d^2 * 2^32 >= F^2 * V
    function automatic bit reaches_threshold(input logic [23:0] x);
        logic [191:0] n, xw, s, q, f, nx, d, nq, ss, spread, lhs, rhs;
        n  = 192'(n_loaded);
        xw = 192'(x);
        s  = 192'(sum_acc);
        q  = 192'(sq_acc);
        f  = 192'(factor);
        nx = n * xw;
        if (nx < s)
            return 1'b0;
        d      = nx - s;
        nq     = n * q;
        ss     = s * s;
        spread = (nq >= ss) ? nq - ss : '0;
        rhs    = (f * f) * spread;
        lhs    = (d * d) << 32;
        lhs[191:128] = '0;
        rhs[191:128] = '0;
        return lhs >= rhs;
    endfunction

    function automatic bit classify_word(input t_word w, output t_result r);
        logic [23:0] v;
        r.status = ST_LOADED;
        r.open   = 1'b0;
        r.stored = '0;
        case (w.req)
            REQ_LOAD: begin
                if (n_loaded == PORTS) begin
                    r.status = ST_DROPPED;
                end else begin
                    v = (w.sample > SAMPLE_MAX) ? SAMPLE_MAX[23:0] : w.sample[23:0];
                    sample_mem[n_loaded[15:0]] = v;
                    n_loaded = n_loaded + 17'd1;
                    sum_acc  = sum_acc + 40'(v);
                    sq_acc   = sq_acc + 64'(v) * 64'(v);
                end
            end
            REQ_QUERY: begin
                if (17'(w.idx) >= n_loaded) begin
                    r.status = ST_NOT_LOADED;
                end else begin
                    r.stored = sample_mem[w.idx];
                    r.open   = reaches_threshold(r.stored);
                    r.status = ST_ANSWERED;
                end
            end
            REQ_CLEAR: begin
                n_loaded = '0;
                sum_acc  = '0;
                sq_acc   = '0;
                r.status = ST_CLEARED;
            end
            default: return 1'b0;
        endcase
        r.loaded = n_loaded;
        return 1'b1;
    endfunction

    // driver
    t_word   cur_word;
    t_result cur_result;
    bit      offer;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            offer = i_s_axis_tvalid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                if (classify_word(cur_word, cur_result))
                    expected_results.insert(expected_results.size(), cur_result);
                accepted_total++;
                offer = 1'b0;
            end
            if (!offer && pending_words.size() > 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                cur_word = pending_words.pop_front();
                i_s_axis_tdata <= {cur_word.idx, cur_word.sample};
                i_s_axis_tuser <= cur_word.req;
                offer = 1'b1;
            end
            i_s_axis_tvalid <= offer;
        end
    end

    // receiver, with long hold-offs counted here
    always @(posedge i_clk) begin
        if (stall_token != stall_seen) begin
            stall_seen = stall_token;
            stall_left = HOLD_LEN;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    t_result exp_r;
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, tdata %h tuser %h",
                         $realtime, o_m_axis_tdata, o_m_axis_tuser);
            end else begin
                exp_r = expected_results.pop_front();
                if (o_m_axis_tuser != exp_r.status) begin
                    errors++;
                    $display("%0t: status exp %0d got %0d", $realtime, exp_r.status,
                             o_m_axis_tuser);
                end
                if (o_m_axis_tdata[0] != exp_r.open) begin
                    errors++;
                    $display("%0t: port_open exp %0d got %0d", $realtime, exp_r.open,
                             o_m_axis_tdata[0]);
                end
                if (o_m_axis_tdata[24:1] != exp_r.stored) begin
                    errors++;
                    $display("%0t: stored_count exp %0h got %0h", $realtime, exp_r.stored,
                             o_m_axis_tdata[24:1]);
                end
                if (o_m_axis_tdata[41:25] != exp_r.loaded) begin
                    errors++;
                    $display("%0t: loaded_total exp %0d got %0d", $realtime, exp_r.loaded,
                             o_m_axis_tdata[41:25]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > RUN_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_word(input logic [1:0] req, input logic [31:0] sample,
                             input logic [15:0] idx);
        t_word w;
        w.req    = req;
        w.sample = sample;
        w.idx    = idx;
        pending_words.insert(pending_words.size(), w);
        queued_total++;
        if (req == REQ_LOAD && gen_loaded < PORTS)
            gen_loaded++;
        else if (req == REQ_CLEAR)
            gen_loaded = 0;
    endtask

    task automatic push_load(input logic [31:0] sample);
        push_word(REQ_LOAD, sample, 16'($urandom_range(65535)));
    endtask

    task automatic push_query(input logic [15:0] idx);
        push_word(REQ_QUERY, $urandom(), idx);
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(11))
            0:       return $urandom();
            1:       return 32'($urandom_range(3));
            2:       return SAMPLE_MAX - 32'($urandom_range(3));
            3:       return $urandom() | 32'h0100_0000;
            4:       return 32'($urandom_range(255));
            default: return cluster_base + 32'($urandom_range(cluster_spread));
        endcase
    endfunction

    function automatic logic [15:0] pick_index();
        if (gen_loaded > 0 && $urandom_range(9) < 8)
            return 16'($urandom_range(gen_loaded - 1));
        case ($urandom_range(2))
            0:       return (gen_loaded < PORTS) ? 16'(gen_loaded) : 16'hFFFF;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic push_random(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(39) == 0) begin
                cluster_base   = (($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(5000)));
                cluster_spread = 1 << $urandom_range(12);
                if ($urandom_range(1))
                    push_word(REQ_CLEAR, $urandom(), 16'($urandom_range(65535)));
            end
            r = $urandom_range(99);
            if (r < 2)
                push_word(REQ_CLEAR, $urandom(), 16'($urandom_range(65535)));
            else if (r < 4)
                push_word(REQ_UNKNOWN, $urandom(), 16'($urandom_range(65535)));
            else if (r < 50)
                push_load(pick_sample());
            else
                push_query(pick_index());
        end
    endtask

    task automatic wait_drained();
        while (queued_total != accepted_total || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_factor(input logic [23:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        factor = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: empty store, single sample, saturation, equal samples, clear
        push_query(16'd0);
        push_load(32'd0);
        push_query(16'd0);
        push_load(32'hFFFF_FFFF);
        push_load(32'h00FF_FFFF);
        push_load(32'h0100_0000);
        push_load(32'd1);
        for (int i = 0; i < 5; i++)
            push_query(16'(i));
        push_query(16'd5);
        push_query(16'hFFFF);
        push_word(REQ_UNKNOWN, 32'hFFFF_FFFF, 16'hFFFF);
        push_word(REQ_CLEAR, 32'hFFFF_FFFF, 16'hFFFF);
        push_query(16'd0);
        push_load(32'd7);
        push_load(32'd7);
        push_query(16'd1);
        push_load(32'h8000_0000);
        push_query(16'd2);
        push_word(REQ_CLEAR, 32'd0, 16'd0);
        wait_drained();

        // no idling, factor zero, long receiver hold-off
        set_factor(24'd0);
        push_random(300);
        stall_token++;
        wait_drained();

        set_idling(88, 0);
        set_factor(24'hFF_FFFF);
        push_random(300);
        wait_drained();

        set_idling(0, 88);
        set_factor(24'd65536);
        push_random(150);
        stall_token++;
        wait_drained();
        push_random(150);
        wait_drained();

        set_idling(7, 7);
        set_factor(24'($urandom_range(24'hFF_FFFF)));
        push_random(350);
        wait_drained();

        set_idling(0, 0);
        set_factor(24'($urandom_range(200000)));
        push_random(150);
        wait_drained();
        push_random(150);
        wait_drained();

        // edge indexes on a partly filled store
        set_factor(24'($urandom_range(131072)));
        push_word(REQ_CLEAR, 32'd0, 16'd0);
        push_random(200);
        push_query(16'd0);
        push_query(16'hFFFF);
        push_query(16'h8000);
        for (int i = 0; i < 10; i++)
            push_query(16'($urandom_range(65535)));
        push_load($urandom());
        push_word(REQ_CLEAR, 32'd0, 16'd0);
        push_load(32'd9);
        push_query(16'd0);
        push_query(16'd1);
        wait_drained();

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
